// ===== sv/fpba_pkg.sv =====
package fpba_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = $clog2(NUM_BLOCKS);
    localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);
    localparam int FIELD_BITS = 16;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_NEXT  = 2'd2;
    localparam logic [1:0] MODE_WORST = 2'd3;

    localparam logic REG_FIT_MODE      = 1'b0;
    localparam logic REG_BLOCKS_IN_USE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } t_step;

    typedef enum logic [1:0] {
        C_DISPATCH,
        C_UNTIL_LAST,
        C_ALWAYS
    } t_cond;

    typedef struct packed {
        logic  busy;
        logic  rd;
        logic  load;
        logic  commit;
        t_cond cond;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic last;
        logic empty;
    } t_status;

    typedef struct packed {
        logic [1:0]          mode;
        logic [CNT_BITS-1:0] count;
    } t_cfg;

    function automatic t_ctrl micro_rom(input t_step s);
        t_ctrl w;
        w = '{busy: 1'b1, rd: 1'b0, load: 1'b0, commit: 1'b0,
              cond: C_ALWAYS, target: ST_IDLE};
        case (s)
            ST_IDLE: begin
                w.busy = 1'b0;
                w.cond = C_DISPATCH;
            end
            ST_LOAD: begin
                w.load = 1'b1;
            end
            ST_SCAN: begin
                w.rd     = 1'b1;
                w.cond   = C_UNTIL_LAST;
                w.target = ST_DRAIN;
            end
            ST_DRAIN: begin
                w.target = ST_WRITE;
            end
            ST_WRITE: begin
                w.commit = 1'b1;
            end
            default: begin
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== sv/fit_policy_block_allocator.sv =====
// Block allocator with a choice of fit policy over a table of sixteen free sizes.
// A word is offered on i_req_type, i_block_index and i_size_value with i_start,
// and it is taken at a clock edge where i_start is high and o_busy is low.
// A load word writes one block's free size and returns the next-fit pointer to
// block zero; it gives no result and holds o_busy high for one cycle.
// An allocate word scans the searchable blocks one per cycle through the
// table's single read port, under a small microcoded sequencer. o_busy stays
// high through the scan, drain and write steps after acceptance, and the
// result word appears on o_result_valid for one cycle straight after, so a
// new allocate can be accepted while that result is shown.
// With no block searchable o_busy is high for one cycle before the result.
// The receiver cannot stall: a result is present for exactly one cycle.
// The policy and block count are set through APB at byte addresses 0 and 4; the
// user must set them only while the block is idle; the block does not enforce it.
// Reset clears the sequencer, the pointer and the strobes, sets first fit and
// sixteen blocks; the size table holds nothing defined until it is loaded.
module fit_policy_block_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_req_type,
    input  logic [fpba_pkg::IDX_BITS-1:0]       i_block_index,
    input  logic [fpba_pkg::FIELD_BITS-1:0]     i_size_value,
    output logic                                o_result_valid,
    output logic                                o_granted,
    output logic [fpba_pkg::IDX_BITS-1:0]       o_block_number,
    output logic [fpba_pkg::FIELD_BITS-1:0]     o_size_left,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int CW = fpba_pkg::CNT_BITS;

    logic [1:0]    r_fit_mode;
    logic [CW-1:0] r_blocks_in_use;

    fpba_pkg::t_ctrl   ctrl;
    fpba_pkg::t_status status;
    fpba_pkg::t_cfg    cfg;
    logic              accept;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign accept = i_start && !ctrl.busy;
    assign o_busy = ctrl.busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode      <= fpba_pkg::MODE_FIRST;
            r_blocks_in_use <= CW'(fpba_pkg::NUM_BLOCKS);
        end else if (wr_en) begin
            if (paddr[2] == fpba_pkg::REG_FIT_MODE) begin
                r_fit_mode <= pwdata[1:0];
            end else begin
                r_blocks_in_use <= pwdata[CW-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == fpba_pkg::REG_BLOCKS_IN_USE) begin
            prdata = 32'(r_blocks_in_use);
        end else begin
            prdata = 32'(r_fit_mode);
        end
    end

    assign cfg.mode  = r_fit_mode;
    assign cfg.count = r_blocks_in_use;

    fpba_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    fpba_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_cfg          (cfg),
        .i_accept       (accept),
        .i_block_index  (i_block_index),
        .i_size_value   (i_size_value),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_granted      (o_granted),
        .o_block_number (o_block_number),
        .o_size_left    (o_size_left)
    );

endmodule

// ===== sv/fpba_seq.sv =====
module fpba_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_req_type,
    input  fpba_pkg::t_status i_status,
    output fpba_pkg::t_ctrl   o_ctrl
);

    fpba_pkg::t_step r_step;
    fpba_pkg::t_step n_step;

    always_comb begin
        n_step = r_step;
        case (o_ctrl.cond)
            fpba_pkg::C_DISPATCH: begin
                if (i_start) begin
                    if (i_req_type == fpba_pkg::REQ_LOAD) begin
                        n_step = fpba_pkg::ST_LOAD;
                    end else if (i_status.empty) begin
                        n_step = fpba_pkg::ST_WRITE;
                    end else begin
                        n_step = fpba_pkg::ST_SCAN;
                    end
                end
            end
            fpba_pkg::C_UNTIL_LAST: begin
                if (i_status.last) begin
                    n_step = o_ctrl.target;
                end
            end
            fpba_pkg::C_ALWAYS: begin
                n_step = o_ctrl.target;
            end
            default: begin
                n_step = fpba_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl = fpba_pkg::micro_rom(r_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= fpba_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== sv/fpba_dp.sv =====
module fpba_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fpba_pkg::t_ctrl                     i_ctrl,
    input  fpba_pkg::t_cfg                      i_cfg,
    input  logic                                i_accept,
    input  logic [fpba_pkg::IDX_BITS-1:0]       i_block_index,
    input  logic [fpba_pkg::FIELD_BITS-1:0]     i_size_value,
    output fpba_pkg::t_status                   o_status,
    output logic                                o_result_valid,
    output logic                                o_granted,
    output logic [fpba_pkg::IDX_BITS-1:0]       o_block_number,
    output logic [fpba_pkg::FIELD_BITS-1:0]     o_size_left
);

    localparam int IW = fpba_pkg::IDX_BITS;
    localparam int CW = fpba_pkg::CNT_BITS;
    localparam int SW = fpba_pkg::SIZE_BITS;

    logic [SW-1:0] mem [fpba_pkg::NUM_BLOCKS];

    logic [SW-1:0] r_req;
    logic [IW-1:0] r_ld_idx;
    logic [IW-1:0] r_addr;
    logic [IW-1:0] r_cnt;
    logic [SW-1:0] r_rdata;
    logic [IW-1:0] r_ridx;
    logic          r_rvalid;
    logic          r_found;
    logic [IW-1:0] r_best_idx;
    logic [SW-1:0] r_best_size;
    logic [IW-1:0] r_ptr;
    logic          r_out_valid;
    logic          r_granted;
    logic [IW-1:0] r_block_number;
    logic [fpba_pkg::FIELD_BITS-1:0] r_size_left;

    logic [CW-1:0] num;
    logic [CW-1:0] num_m1;
    logic [IW-1:0] start_idx;
    logic [IW-1:0] next_addr;
    logic          fits;
    logic          take;
    logic [SW-1:0] left;

    always_comb begin
        if (i_cfg.count > CW'(fpba_pkg::NUM_BLOCKS)) begin
            num = CW'(fpba_pkg::NUM_BLOCKS);
        end else begin
            num = i_cfg.count;
        end
        num_m1 = num - CW'(1);
        if (i_cfg.mode == fpba_pkg::MODE_NEXT && CW'(r_ptr) < num) begin
            start_idx = r_ptr;
        end else begin
            start_idx = '0;
        end
        if (CW'(r_addr) == num_m1) begin
            next_addr = '0;
        end else begin
            next_addr = r_addr + IW'(1);
        end
        fits = (r_rdata >= r_req);
        take = r_rvalid && fits && (!r_found
               || (i_cfg.mode == fpba_pkg::MODE_BEST && r_rdata < r_best_size)
               || (i_cfg.mode == fpba_pkg::MODE_WORST && r_rdata > r_best_size));
        left = r_best_size - r_req;
    end

    assign o_status.last  = (CW'(r_cnt) == num_m1);
    assign o_status.empty = (num == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            mem[r_ld_idx] <= r_req;
        end else if (i_ctrl.commit && r_found) begin
            mem[r_best_idx] <= left;
        end
        if (i_ctrl.rd) begin
            r_rdata <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_req    <= SW'(i_size_value);
            r_ld_idx <= i_block_index;
            r_addr   <= start_idx;
            r_cnt    <= '0;
        end else if (i_ctrl.rd) begin
            r_ridx <= r_addr;
            r_addr <= next_addr;
            r_cnt  <= r_cnt + IW'(1);
        end
        if (take) begin
            r_best_idx  <= r_ridx;
            r_best_size <= r_rdata;
        end
        if (i_ctrl.commit) begin
            r_granted      <= r_found;
            r_block_number <= r_found ? r_best_idx : '0;
            r_size_left    <= r_found ? fpba_pkg::FIELD_BITS'(left) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid    <= 1'b0;
            r_found     <= 1'b0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rvalid    <= i_ctrl.rd;
            r_out_valid <= i_ctrl.commit;
            if (i_accept) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
            if (i_ctrl.load) begin
                r_ptr <= '0;
            end else if (i_ctrl.commit && r_found && i_cfg.mode == fpba_pkg::MODE_NEXT) begin
                r_ptr <= r_best_idx;
            end
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_granted      = r_granted;
    assign o_block_number = r_block_number;
    assign o_size_left    = r_size_left;

endmodule
